FILE: design/bezier_curve_length_macros.svh
// Assertion macros for the cubic Bezier arc length block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef BEZIER_CURVE_LENGTH_MACROS_SVH
`define BEZIER_CURVE_LENGTH_MACROS_SVH

// same-cycle implication, disabled during reset
`define BCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bezier_curve_length: assertion failed");

// next-cycle implication, disabled during reset
`define BCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bezier_curve_length: assertion failed");

// state in the cycle after reset is applied
`define BCL_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("bezier_curve_length: reset check failed");

`endif

FILE: design/bcl_pkg.sv
// Shared constants and types for the cubic Bezier arc length block.
// No dependencies; used by the square root unit and the top level.
package bcl_pkg;

  localparam int unsigned BCL_SAMPLE_COUNT = 20;

  localparam logic [31:0] T_STEP   = 32'h0000_0CCC;
  localparam logic [31:0] T_ONE    = 32'h0001_0000;
  localparam logic [31:0] SQRT_TOP = 32'h4000_0000;

  // status of the square root unit as seen by the sequencer
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] root;
  } sqrt_stat_t;

endpackage

FILE: design/bcl_mul.sv
// Shared 32x32 multiplier, low 32 bits of the product, output registered.
// No dependencies; operands are selected by the top-level sequencer.
module bcl_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] prod
);

  logic [31:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

FILE: design/bcl_sqrt.sv
// Digit-by-digit square root of a 32-bit value, rounded to nearest.
// One result bit per cycle, 16 iterations. Depends on bcl_pkg.
module bcl_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         val,
  output bcl_pkg::sqrt_stat_t stat
);
  import bcl_pkg::*;

  logic [31:0] rem_r;
  logic [31:0] acc_r;
  logic [31:0] bit_r;
  logic [15:0] root_r;
  logic        busy_r;
  logic        done_r;

  logic [32:0] trial;
  logic        fits;
  logic [31:0] acc_step;
  logic        load;

  assign load = start && !busy_r;

  always_comb begin
    trial    = {1'b0, acc_r} + {1'b0, bit_r};
    fits     = {1'b0, rem_r} >= trial;
    acc_step = fits ? (acc_r + (bit_r << 1)) : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (bit_r == '0);
      if (load) begin
        busy_r <= 1'b1;
      end else if (busy_r && (bit_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= val;
      acc_r <= '0;
      bit_r <= SQRT_TOP;
    end else if (busy_r && (bit_r != '0)) begin
      if (fits) begin
        rem_r <= rem_r - trial[31:0];
      end
      acc_r <= acc_step >> 1;
      bit_r <= bit_r >> 2;
    end else if (busy_r) begin
      // round up when the remainder exceeds the floor root
      root_r <= (rem_r <= acc_r) ? acc_r[15:0] : (acc_r[15:0] + 16'd1);
    end
  end

  assign stat = '{busy: busy_r, done: done_r, root: root_r};

endmodule

FILE: design/bezier_curve_length.sv
// Cubic Bezier arc length by chord sampling, 16.16 fixed point.
// Each sample runs the 16 products of its step sequence through the single shared multiplier;
// the square root unit overlaps with the next sample, which waits in its root step while the
// unit is still busy. A new transaction is taken only after the last result is issued.
// Synchronous active-low reset empties the block.
module bezier_curve_length #(
  parameter int unsigned SAMPLE_COUNT = bcl_pkg::BCL_SAMPLE_COUNT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_ctrl_a_x,
  input  logic signed [31:0] in_ctrl_a_y,
  input  logic signed [31:0] in_ctrl_b_x,
  input  logic signed [31:0] in_ctrl_b_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_arc_length
);
  import bcl_pkg::*;

  localparam int unsigned KW = $clog2(SAMPLE_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  // mostly named by the product issued in that step; ST_DX and ST_DY form the chord deltas
  typedef enum logic [4:0] {
    ST_UU, ST_TT, ST_W0, ST_W1, ST_W2, ST_W3,
    ST_X0, ST_Y0, ST_X1, ST_Y1, ST_X2, ST_Y2, ST_X3, ST_Y3,
    ST_DX, ST_DY, ST_SQY, ST_SQ, ST_ROOT
  } step_t;

  function automatic logic [31:0] ext_int(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [15:0] mag_hi(input logic [31:0] d);
    logic [31:0] m;
    m = d[31] ? (32'd0 - d) : d;
    return m[31:16];
  endfunction

  state_t        state_r;
  step_t         step_r;
  logic          out_valid_r;
  logic [31:0]   out_len_r;

  logic [15:0]   ih_r [8];
  logic [KW-1:0] k_r;
  logic [31:0]   t_r, u_r, u2_r, t2_r;
  logic [31:0]   w0_r, w1x3_r, w2x3_r, w3_r;
  logic [31:0]   qx_r, qy_r, px_r, py_r;
  logic [15:0]   ix_r, iy_r;
  logic [31:0]   sq_r, total_r;

  logic [31:0]   mul_a, mul_b, prod, wprod;
  sqrt_stat_t    sq_stat;
  logic          accept, sqrt_start, last_sample, drain_go;

  assign accept      = in_valid && (state_r == S_IDLE);
  assign last_sample = (k_r == KW'(SAMPLE_COUNT));
  assign sqrt_start  = (state_r == S_RUN) && (step_r == ST_ROOT) && !sq_stat.busy;
  assign drain_go    = (state_r == S_DRAIN) && !sq_stat.busy && !sq_stat.done
                       && (!out_valid_r || !out_stall);
  assign wprod       = {16'h0, prod[31:16]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r) inside
      ST_UU:  begin mul_a = u_r;    mul_b = u_r;              end
      ST_TT:  begin mul_a = t_r;    mul_b = t_r;              end
      ST_W0:  begin mul_a = u_r;    mul_b = u2_r;             end
      ST_W1:  begin mul_a = t_r;    mul_b = u2_r;             end
      ST_W2:  begin mul_a = u_r;    mul_b = t2_r;             end
      ST_W3:  begin mul_a = t_r;    mul_b = t2_r;             end
      ST_X0:  begin mul_a = w0_r;   mul_b = ext_int(ih_r[0]); end
      ST_Y0:  begin mul_a = w0_r;   mul_b = ext_int(ih_r[1]); end
      ST_X1:  begin mul_a = w1x3_r; mul_b = ext_int(ih_r[2]); end
      ST_Y1:  begin mul_a = w1x3_r; mul_b = ext_int(ih_r[3]); end
      ST_X2:  begin mul_a = w2x3_r; mul_b = ext_int(ih_r[4]); end
      ST_Y2:  begin mul_a = w2x3_r; mul_b = ext_int(ih_r[5]); end
      ST_X3:  begin mul_a = w3_r;   mul_b = ext_int(ih_r[6]); end
      ST_Y3:  begin mul_a = w3_r;   mul_b = ext_int(ih_r[7]); end
      ST_DY:  begin mul_a = {16'h0, ix_r}; mul_b = {16'h0, ix_r}; end
      ST_SQY: begin mul_a = {16'h0, iy_r}; mul_b = {16'h0, iy_r}; end
      ST_DX, ST_SQ, ST_ROOT: begin end
      default: begin end
    endcase
  end

  bcl_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bcl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .val   (sq_r),
    .stat  (sq_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_UU;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !drain_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RUN;
            step_r  <= ST_UU;
          end
        end
        S_RUN: begin
          if (step_r == ST_ROOT) begin
            if (!sq_stat.busy) begin
              step_r <= ST_UU;
              if (last_sample) begin
                state_r <= S_DRAIN;
              end
            end
          end else begin
            step_r <= step_t'(step_r + 5'd1);
          end
        end
        S_DRAIN: begin
          if (drain_go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath; each step after a product step writes back the product issued in the step before
  always_ff @(posedge clk) begin
    if (accept) begin
      ih_r[0] <= in_start_x[31:16];
      ih_r[1] <= in_start_y[31:16];
      ih_r[2] <= in_ctrl_a_x[31:16];
      ih_r[3] <= in_ctrl_a_y[31:16];
      ih_r[4] <= in_ctrl_b_x[31:16];
      ih_r[5] <= in_ctrl_b_y[31:16];
      ih_r[6] <= in_end_x[31:16];
      ih_r[7] <= in_end_y[31:16];
      px_r    <= in_start_x;
      py_r    <= in_start_y;
      t_r     <= T_STEP;
      u_r     <= T_ONE - T_STEP;
      k_r     <= KW'(1);
      total_r <= '0;
    end
    if (sq_stat.done) begin
      total_r <= total_r + {sq_stat.root, 16'h0};
    end
    if (drain_go) begin
      out_len_r <= total_r;
    end
    if (state_r == S_RUN) begin
      unique case (step_r) inside
        ST_TT:  u2_r   <= wprod;
        ST_W0:  t2_r   <= wprod;
        ST_W1:  w0_r   <= wprod;
        ST_W2:  w1x3_r <= (wprod << 1) + wprod;
        ST_W3:  w2x3_r <= (wprod << 1) + wprod;
        ST_X0:  w3_r   <= wprod;
        ST_Y0:  qx_r   <= prod;
        ST_X1:  qy_r   <= prod;
        ST_Y1, ST_Y2, ST_Y3: qx_r <= qx_r + prod;
        ST_X2, ST_X3:        qy_r <= qy_r + prod;
        ST_DX: begin
          qy_r <= qy_r + prod;
          ix_r <= mag_hi(qx_r - px_r);
          px_r <= qx_r;
        end
        ST_DY: begin
          iy_r <= mag_hi(qy_r - py_r);
          py_r <= qy_r;
        end
        ST_SQY: sq_r <= prod;
        ST_SQ:  sq_r <= sq_r + prod;
        ST_ROOT: begin
          if (!sq_stat.busy) begin
            t_r <= t_r + T_STEP;
            u_r <= u_r - T_STEP;
            k_r <= k_r + KW'(1);
          end
        end
        ST_UU: begin end
        default: begin end
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_arc_length = out_len_r;

endmodule

FILE: design/bcl_checker.sv
// Port-level checks for the cubic Bezier arc length block, bound to the top level.
// Depends on bezier_curve_length_macros.svh.
`include "bezier_curve_length_macros.svh"

module bcl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_arc_length
);

  // a held result keeps its value
  `BCL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_arc_length))
  // one transaction at a time: the block is busy right after taking one
  `BCL_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a new result appears only as the block goes back to idle
  `BCL_ASSERT_IMP(a_result_when_idle, $rose(out_valid), !in_stall)
  `BCL_ASSERT_RST(a_reset_empty, !out_valid && !in_stall)

endmodule

bind bezier_curve_length bcl_checker u_bcl_checker (.*);
